// ----- hdl/sters_pkg.sv -----
// Shared constants, opcodes and result type for the sorted table equal-range search block.
`timescale 1ns / 1ps
`default_nettype none

package sters_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Stream widths; the tdata widths are rounded up to whole bytes
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OP_W        = 2;
    localparam int OUT_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * IDX_W;

    // Operation codes carried on the input tuser
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // One query result
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
    } res_t;

endpackage

`default_nettype wire

// ----- hdl/sters_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sters_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/sters_ctrl.sv -----
// Sequencer: table fill count, append and clear handling, and the two binary searches.
`timescale 1ns / 1ps
`default_nettype none

module sters_ctrl import sters_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [OP_W-1:0]        in_op,
    input  wire logic [VALUE_WIDTH-1:0] in_value,
    output logic                        res_valid,
    input  wire logic                   res_free,
    output res_t                        res,
    output logic                        mem_we,
    output logic [IDX_W-1:0]            mem_waddr,
    output logic [VALUE_WIDTH-1:0]      mem_wdata,
    output logic [IDX_W-1:0]            mem_raddr,
    input  wire logic [VALUE_WIDTH-1:0] mem_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_SRCH  = 5'b00100,
        ST_CHK   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                 state_reg,    state_next;
    logic [CNT_W-1:0]       count_reg,    count_next;
    logic [IDX_W-1:0]       lo_reg,       lo_next;
    logic [IDX_W-1:0]       hi_reg,       hi_next;
    logic [IDX_W-1:0]       mid_reg,      mid_next;
    logic [VALUE_WIDTH-1:0] key_reg,      key_next;
    logic                   upper_reg,    upper_next;
    logic                   eq_first_reg, eq_first_next;
    logic [IDX_W-1:0]       first_reg,    first_next;
    res_t                   res_reg,      res_next;

    logic                   accept;
    logic [IDX_W-1:0]       lo_upd;
    logic [IDX_W-1:0]       hi_upd;
    logic [CNT_W-1:0]       span;
    logic [IDX_W-1:0]       mid_new;
    logic                   more;
    logic [IDX_W-1:0]       last_pos;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;
    assign last_pos  = IDX_W'(count_reg - CNT_W'(1));

    // Narrow the search window with the entry read last cycle
    always_comb
    begin
        lo_upd = lo_reg;
        hi_upd = hi_reg;
        if (state_reg == ST_SRCH)
        begin
            if (!upper_reg)
            begin
                if (mem_rdata >= key_reg)
                begin
                    hi_upd = mid_reg;
                end
                else
                begin
                    lo_upd = mid_reg + IDX_W'(1);
                end
            end
            else
            begin
                if (mem_rdata <= key_reg)
                begin
                    lo_upd = mid_reg;
                end
                else
                begin
                    hi_upd = mid_reg - IDX_W'(1);
                end
            end
        end
    end

    // Pick the next probe: midpoint while the window is open, else its final position
    always_comb
    begin
        span    = {1'b0, hi_upd} - {1'b0, lo_upd} + (upper_reg ? CNT_W'(1) : CNT_W'(0));
        mid_new = lo_upd + IDX_W'(span >> 1);
        more    = (lo_upd < hi_upd);
    end

    assign mem_raddr = more ? mid_new : lo_upd;

    // Append writes the next free entry
    assign mem_we    = accept && (in_op == OP_APPEND) && (count_reg < CNT_W'(TABLE_DEPTH));
    assign mem_waddr = IDX_W'(count_reg);
    assign mem_wdata = in_value;

    // Sequence the items
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        key_next      = key_reg;
        upper_next    = upper_reg;
        eq_first_next = eq_first_reg;
        first_next    = first_reg;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_APPEND:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_QUERY:
                        begin
                            key_next   = in_value;
                            upper_next = 1'b0;
                            lo_next    = '0;
                            hi_next    = last_pos;
                            if (count_reg == '0)
                            begin
                                res_next   = '0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_START;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START, ST_SRCH:
            begin
                lo_next    = lo_upd;
                hi_next    = hi_upd;
                mid_next   = mid_new;
                state_next = more ? ST_SRCH : ST_CHK;
            end
            ST_CHK:
            begin
                if (!upper_reg)
                begin
                    // Hold the lower bound, restart for the upper bound
                    eq_first_next = (mem_rdata == key_reg);
                    first_next    = lo_reg;
                    upper_next    = 1'b1;
                    lo_next       = '0;
                    hi_next       = last_pos;
                    state_next    = ST_START;
                end
                else
                begin
                    if (eq_first_reg && (mem_rdata == key_reg))
                    begin
                        res_next.found       = 1'b1;
                        res_next.first_index = first_reg;
                        res_next.last_index  = lo_reg;
                    end
                    else
                    begin
                        res_next = '0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Search datapath
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        upper_reg    <= upper_next;
        eq_first_reg <= eq_first_next;
        first_reg    <= first_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

// ----- hdl/sorted_table_equal_range_search_core.sv -----
// Top level of the sorted table equal-range search: stream ports, table memory and output register.
//
//  Channel  Direction  tdata (low bit up)                    tuser
//  s_axis   in         value[15:0]                           op[1:0]
//  m_axis   out        first_index[9:0], last_index[9:0], 0  found
//
// Append and clear are taken in the idle state and leave the input open for the next item.
// A query holds the input closed while it searches: each search step is one read of the single
// table read port, and the two searches run one after the other.
// rst_n clears the fill count and the control state; the table contents are not cleared.
// A finished result waits in the output register; the next item is taken meanwhile, and
// a query stalls only when its own result finds the register still full.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_equal_range_search_core import sters_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value
    input  wire logic [OP_W-1:0]        s_axis_tuser,   // op
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // first_index, last_index, zero pad
    output logic                        m_axis_tuser    // found
);

    logic                   res_valid;
    logic                   res_free;
    res_t                   res;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg,   out_res_next;

    sters_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_value  (s_axis_tdata[VALUE_WIDTH-1:0]),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sters_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Load the output register when it is empty or its transfer completes
    assign res_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_free)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // Drive the result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.found;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg.last_index, out_res_reg.first_index};

endmodule

`default_nettype wire

// ----- hdl/sters_chk.sv -----
// Port-level checker for the search core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sters_chk import sters_pkg::*; (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [OP_W-1:0]        s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A miss reports both positions as zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss carries non-zero positions");

    // A query keeps the input closed while it searches
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
        else $error("input open right after a query transfer");

endmodule

bind sorted_table_equal_range_search_core sters_chk u_sters_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- dv/sorted_table_equal_range_search_core_tb.sv -----
// Self-checking testbench for the sorted table equal-range search core.
`timescale 1ns / 1ps

module sorted_table_equal_range_search_core_tb;

    import sters_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PRINT_LIMIT    = 40;

    // Equal-range predictor: a private copy of the table and the queue of query outcomes
    class range_search_model;
        logic [VALUE_WIDTH-1:0] entries [TABLE_DEPTH];
        int unsigned            fill;
        res_t                   pending_ranges [$];
        int                     error_count;

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        function int outstanding();
            return pending_ranges.size();
        endfunction

        // Lowest position in [0, top] whose entry is at or above the key
        function int unsigned first_at_or_above(int unsigned top, logic [VALUE_WIDTH-1:0] key);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = top;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] >= key)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            return lo;
        endfunction

        // Highest position in [0, top] whose entry is at or below the key
        function int unsigned last_at_or_below(int unsigned top, logic [VALUE_WIDTH-1:0] key);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = top;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (entries[mid] <= key)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        // Apply one accepted input transfer to the table and queue any query outcome
        function void note_item(logic [OP_W-1:0] op, logic [VALUE_WIDTH-1:0] value);
            res_t        outcome;
            int unsigned lo_pos;
            int unsigned hi_pos;
            case (op)
                OP_APPEND:
                begin
                    // drop appends once the table is full
                    if (fill < TABLE_DEPTH)
                    begin
                        entries[fill] = value;
                        fill++;
                    end
                end
                OP_CLEAR:
                    fill = 0;
                OP_QUERY:
                begin
                    outcome = '0;
                    if (fill != 0)
                    begin
                        lo_pos = first_at_or_above(fill - 1, value);
                        hi_pos = last_at_or_below(fill - 1, value);
                        if (entries[lo_pos] == value && entries[hi_pos] == value)
                        begin
                            outcome.found       = 1'b1;
                            outcome.first_index = lo_pos[IDX_W-1:0];
                            outcome.last_index  = hi_pos[IDX_W-1:0];
                        end
                    end
                    pending_ranges.push_back(outcome);
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string what);
            // keep the log short when everything goes wrong
            if (error_count < PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            error_count++;
        endtask

        // Compare one result transfer with the oldest outstanding query
        task check_range(res_t got);
            res_t want;
            if (pending_ranges.size() == 0)
            begin
                report_mismatch("result transfer with no query outstanding");
                return;
            end
            want = pending_ranges.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.first_index !== want.first_index)
                report_mismatch($sformatf("first_index %0d, expected %0d",
                                          got.first_index, want.first_index));
            if (got.last_index !== want.last_index)
                report_mismatch($sformatf("last_index %0d, expected %0d",
                                          got.last_index, want.last_index));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    range_search_model board = new();

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int useful_items;
    int quiet_cycles;

    sorted_table_equal_range_search_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, idling first at random, and hold it until the transfer
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_WIDTH-1:0] value);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op != OP_UNUSED && !(op == OP_APPEND && board.fill >= TABLE_DEPTH))
            useful_items++;
        board.note_item(op, value);
    endtask

    // Pick a search key: mostly stored values and their neighbours, some random, some extremes
    function automatic logic [VALUE_WIDTH-1:0] pick_key();
        int                     sel;
        logic [VALUE_WIDTH-1:0] k;
        sel = $urandom_range(99);
        k   = VALUE_WIDTH'($urandom);
        if (board.fill != 0)
        begin
            k = board.entries[$urandom_range(board.fill - 1)];
            if (sel >= 50 && sel < 65)
                k = k + 1'b1;
            else if (sel >= 65 && sel < 80)
                k = k - 1'b1;
        end
        if (sel >= 80 && sel < 90)
            k = VALUE_WIDTH'($urandom);
        else if (sel >= 90 && sel < 95)
            k = '0;
        else if (sel >= 95)
            k = '1;
        return k;
    endfunction

    // Load a table (ascending or scrambled) and run queries mixed with late appends and noise
    task automatic load_and_query(input int n_entries, input int max_step, input bit ascending,
                                  input bit do_clear, input int n_queries, input bit hold);
        int unsigned            acc;
        int                     step;
        int                     i;
        int                     sel;
        logic [VALUE_WIDTH-1:0] v;
        if (do_clear)
            send_item(OP_CLEAR, VALUE_WIDTH'($urandom));
        acc = (max_step <= 3) ? $urandom_range(65535) : $urandom_range(2000);
        for (i = 0; i < n_entries; i++)
        begin
            step = ($urandom_range(3) == 0) ? 0 : $urandom_range(max_step, 1);
            acc  = (acc + step > 65535) ? 65535 : acc + step;
            v    = ascending ? VALUE_WIDTH'(acc) : VALUE_WIDTH'($urandom);
            send_item(OP_APPEND, v);
        end
        // stall the result side so that queries back up into the input
        if (hold)
            hold_request = 1'b1;
        for (i = 0; i < n_queries; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                send_item(OP_UNUSED, VALUE_WIDTH'($urandom));
            else if (sel < 16)
            begin
                acc = (acc + 1 > 65535) ? 65535 : acc + $urandom_range(1, 0);
                send_item(OP_APPEND, ascending ? VALUE_WIDTH'(acc) : VALUE_WIDTH'($urandom));
            end
            else
                send_item(OP_QUERY, pick_key());
        end
    endtask

    // Directed part: empty table, extremes, duplicates, absent keys, unused op, scrambled loads
    task automatic run_directed();
        send_item(OP_QUERY, 16'd5);
        send_item(OP_UNUSED, 16'd0);
        send_item(OP_APPEND, 16'd0);
        send_item(OP_APPEND, 16'd0);
        send_item(OP_APPEND, 16'd5);
        send_item(OP_APPEND, 16'd5);
        send_item(OP_APPEND, 16'd5);
        send_item(OP_APPEND, 16'd40000);
        send_item(OP_APPEND, 16'hFFFF);
        send_item(OP_QUERY, 16'd0);
        send_item(OP_QUERY, 16'd5);
        send_item(OP_QUERY, 16'hFFFF);
        send_item(OP_QUERY, 16'd1);
        send_item(OP_QUERY, 16'hFFFE);
        send_item(OP_QUERY, 16'd40000);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_CLEAR, 16'hFFFF);
        send_item(OP_QUERY, 16'd5);
        send_item(OP_APPEND, 16'd9);
        send_item(OP_APPEND, 16'd3);
        send_item(OP_APPEND, 16'd9);
        send_item(OP_QUERY, 16'd9);
        send_item(OP_QUERY, 16'd3);
        send_item(OP_QUERY, 16'd7);
        send_item(OP_CLEAR, 16'd0);
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        int seg;
        int kind;
        int steps [5];
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= OP_APPEND;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        steps          = '{0, 1, 3, 50, 2000};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        useful_items = 0;
        seg          = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            // rotate through the idling phases
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            kind = $urandom_range(99);
            if (seg == 6)
                load_and_query(TABLE_DEPTH + 6, 60, 1'b1, 1'b1, 24, 1'b0);
            else if (seg == 4)
                load_and_query($urandom_range(40, 1), 50, 1'b1, 1'b1, 16, 1'b1);
            else if (kind < 70)
                load_and_query($urandom_range(40, 1), steps[$urandom_range(4)], 1'b1,
                               $urandom_range(99) < 85, $urandom_range(12, 4), 1'b0);
            else if (kind < 85)
                load_and_query($urandom_range(20, 1), 0, 1'b0, 1'b1, $urandom_range(10, 4),
                               1'b0);
            else
                repeat (10)
                    send_item(OP_W'($urandom_range(OP_UNUSED)), VALUE_WIDTH'($urandom));
            seg++;
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then allow for a late stray transfer
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.outstanding() != 0)
            board.report_mismatch("queries left without a result");
        if (board.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: random back-pressure, with one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin : collect
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.found       = m_axis_tuser;
            got.first_index = m_axis_tdata[IDX_W-1:0];
            got.last_index  = m_axis_tdata[2*IDX_W-1:IDX_W];
            board.check_range(got);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
